>>> src/tcfx_pkg.sv
// Package for the tracker channel effect engine.
// Holds the period and sine tables, limits and the front-to-back word type.
`default_nettype none
package tcfx_pkg;

  localparam int RowLen = 37;
  localparam int TabLen = 16 * RowLen + 15;
  localparam logic [11:0] PerMin = 12'd113;
  localparam logic [11:0] PerMax = 12'd856;
  localparam logic [6:0] VolMax = 7'd64;
  localparam int QueueDepth = 2;

  localparam logic [3:0] CmdArp = 4'h0;
  localparam logic [3:0] CmdPortaUp = 4'h1;
  localparam logic [3:0] CmdPortaDown = 4'h2;
  localparam logic [3:0] CmdTone = 4'h3;
  localparam logic [3:0] CmdVibrato = 4'h4;
  localparam logic [3:0] CmdToneVol = 4'h5;
  localparam logic [3:0] CmdVibVol = 4'h6;
  localparam logic [3:0] CmdTremolo = 4'h7;
  localparam logic [3:0] CmdRetrig = 4'h9;
  localparam logic [3:0] CmdVolSlide = 4'hA;
  localparam logic [3:0] CmdSetVol = 4'hC;
  localparam logic [3:0] CmdExt = 4'hE;

  localparam logic [3:0] ExtFineUp = 4'h1;
  localparam logic [3:0] ExtFineDown = 4'h2;
  localparam logic [3:0] ExtGliss = 4'h3;
  localparam logic [3:0] ExtVibWave = 4'h4;
  localparam logic [3:0] ExtFinetune = 4'h5;
  localparam logic [3:0] ExtTremWave = 4'h7;
  localparam logic [3:0] ExtRetrig = 4'h9;
  localparam logic [3:0] ExtFineVolUp = 4'hA;
  localparam logic [3:0] ExtFineVolDown = 4'hB;
  localparam logic [3:0] ExtCut = 4'hC;
  localparam logic [3:0] ExtDelay = 4'hD;

  // One input word as handed from the front to the back part.
  typedef struct packed {
    logic mode;
    logic [11:0] note_period;
    logic sample_given;
    logic [3:0] sample_finetune;
    logic [6:0] sample_volume;
    logic [3:0] command;
    logic [7:0] param;
    logic [4:0] tick_index;
  } item_t;

  function automatic logic signed [15:0] per_tab(input logic [9:0] idx);
    logic signed [15:0] r;
    unique case (idx)
      10'd0: r = 856; 10'd1: r = 808; 10'd2: r = 762; 10'd3: r = 720; 10'd4: r = 678;
      10'd5: r = 640; 10'd6: r = 604; 10'd7: r = 570; 10'd8: r = 538; 10'd9: r = 508;
      10'd10: r = 480; 10'd11: r = 453; 10'd12: r = 428; 10'd13: r = 404; 10'd14: r = 381;
      10'd15: r = 360; 10'd16: r = 339; 10'd17: r = 320; 10'd18: r = 302; 10'd19: r = 285;
      10'd20: r = 269; 10'd21: r = 254; 10'd22: r = 240; 10'd23: r = 226; 10'd24: r = 214;
      10'd25: r = 202; 10'd26: r = 190; 10'd27: r = 180; 10'd28: r = 170; 10'd29: r = 160;
      10'd30: r = 151; 10'd31: r = 143; 10'd32: r = 135; 10'd33: r = 127; 10'd34: r = 120;
      10'd35: r = 113; 10'd36: r = 0;
      10'd37: r = 850; 10'd38: r = 802; 10'd39: r = 757; 10'd40: r = 715; 10'd41: r = 674;
      10'd42: r = 637; 10'd43: r = 601; 10'd44: r = 567; 10'd45: r = 535; 10'd46: r = 505;
      10'd47: r = 477; 10'd48: r = 450; 10'd49: r = 425; 10'd50: r = 401; 10'd51: r = 379;
      10'd52: r = 357; 10'd53: r = 337; 10'd54: r = 318; 10'd55: r = 300; 10'd56: r = 284;
      10'd57: r = 268; 10'd58: r = 253; 10'd59: r = 239; 10'd60: r = 225; 10'd61: r = 213;
      10'd62: r = 201; 10'd63: r = 189; 10'd64: r = 179; 10'd65: r = 169; 10'd66: r = 159;
      10'd67: r = 150; 10'd68: r = 142; 10'd69: r = 134; 10'd70: r = 126; 10'd71: r = 119;
      10'd72: r = 113; 10'd73: r = 0;
      10'd74: r = 844; 10'd75: r = 796; 10'd76: r = 752; 10'd77: r = 709; 10'd78: r = 670;
      10'd79: r = 632; 10'd80: r = 597; 10'd81: r = 563; 10'd82: r = 532; 10'd83: r = 502;
      10'd84: r = 474; 10'd85: r = 447; 10'd86: r = 422; 10'd87: r = 398; 10'd88: r = 376;
      10'd89: r = 355; 10'd90: r = 335; 10'd91: r = 316; 10'd92: r = 298; 10'd93: r = 282;
      10'd94: r = 266; 10'd95: r = 251; 10'd96: r = 237; 10'd97: r = 224; 10'd98: r = 211;
      10'd99: r = 199; 10'd100: r = 188; 10'd101: r = 177; 10'd102: r = 167; 10'd103: r = 158;
      10'd104: r = 149; 10'd105: r = 141; 10'd106: r = 133; 10'd107: r = 125; 10'd108: r = 118;
      10'd109: r = 112; 10'd110: r = 0;
      10'd111: r = 838; 10'd112: r = 791; 10'd113: r = 746; 10'd114: r = 704; 10'd115: r = 665;
      10'd116: r = 628; 10'd117: r = 592; 10'd118: r = 559; 10'd119: r = 528; 10'd120: r = 498;
      10'd121: r = 470; 10'd122: r = 444; 10'd123: r = 419; 10'd124: r = 395; 10'd125: r = 373;
      10'd126: r = 352; 10'd127: r = 332; 10'd128: r = 314; 10'd129: r = 296; 10'd130: r = 280;
      10'd131: r = 264; 10'd132: r = 249; 10'd133: r = 235; 10'd134: r = 222; 10'd135: r = 209;
      10'd136: r = 198; 10'd137: r = 187; 10'd138: r = 176; 10'd139: r = 166; 10'd140: r = 157;
      10'd141: r = 148; 10'd142: r = 140; 10'd143: r = 132; 10'd144: r = 125; 10'd145: r = 118;
      10'd146: r = 111; 10'd147: r = 0;
      10'd148: r = 832; 10'd149: r = 785; 10'd150: r = 741; 10'd151: r = 699; 10'd152: r = 660;
      10'd153: r = 623; 10'd154: r = 588; 10'd155: r = 555; 10'd156: r = 524; 10'd157: r = 495;
      10'd158: r = 467; 10'd159: r = 441; 10'd160: r = 416; 10'd161: r = 392; 10'd162: r = 370;
      10'd163: r = 350; 10'd164: r = 330; 10'd165: r = 312; 10'd166: r = 294; 10'd167: r = 278;
      10'd168: r = 262; 10'd169: r = 247; 10'd170: r = 233; 10'd171: r = 220; 10'd172: r = 208;
      10'd173: r = 196; 10'd174: r = 185; 10'd175: r = 175; 10'd176: r = 165; 10'd177: r = 156;
      10'd178: r = 147; 10'd179: r = 139; 10'd180: r = 131; 10'd181: r = 124; 10'd182: r = 117;
      10'd183: r = 110; 10'd184: r = 0;
      10'd185: r = 826; 10'd186: r = 779; 10'd187: r = 736; 10'd188: r = 694; 10'd189: r = 655;
      10'd190: r = 619; 10'd191: r = 584; 10'd192: r = 551; 10'd193: r = 520; 10'd194: r = 491;
      10'd195: r = 463; 10'd196: r = 437; 10'd197: r = 413; 10'd198: r = 390; 10'd199: r = 368;
      10'd200: r = 347; 10'd201: r = 328; 10'd202: r = 309; 10'd203: r = 292; 10'd204: r = 276;
      10'd205: r = 260; 10'd206: r = 245; 10'd207: r = 232; 10'd208: r = 219; 10'd209: r = 206;
      10'd210: r = 195; 10'd211: r = 184; 10'd212: r = 174; 10'd213: r = 164; 10'd214: r = 155;
      10'd215: r = 146; 10'd216: r = 138; 10'd217: r = 130; 10'd218: r = 123; 10'd219: r = 116;
      10'd220: r = 109; 10'd221: r = 0;
      10'd222: r = 820; 10'd223: r = 774; 10'd224: r = 730; 10'd225: r = 689; 10'd226: r = 651;
      10'd227: r = 614; 10'd228: r = 580; 10'd229: r = 547; 10'd230: r = 516; 10'd231: r = 487;
      10'd232: r = 460; 10'd233: r = 434; 10'd234: r = 410; 10'd235: r = 387; 10'd236: r = 365;
      10'd237: r = 345; 10'd238: r = 325; 10'd239: r = 307; 10'd240: r = 290; 10'd241: r = 274;
      10'd242: r = 258; 10'd243: r = 244; 10'd244: r = 230; 10'd245: r = 217; 10'd246: r = 205;
      10'd247: r = 193; 10'd248: r = 183; 10'd249: r = 172; 10'd250: r = 163; 10'd251: r = 154;
      10'd252: r = 145; 10'd253: r = 137; 10'd254: r = 129; 10'd255: r = 122; 10'd256: r = 115;
      10'd257: r = 109; 10'd258: r = 0;
      10'd259: r = 814; 10'd260: r = 768; 10'd261: r = 725; 10'd262: r = 684; 10'd263: r = 646;
      10'd264: r = 610; 10'd265: r = 575; 10'd266: r = 543; 10'd267: r = 513; 10'd268: r = 484;
      10'd269: r = 457; 10'd270: r = 431; 10'd271: r = 407; 10'd272: r = 384; 10'd273: r = 363;
      10'd274: r = 342; 10'd275: r = 323; 10'd276: r = 305; 10'd277: r = 288; 10'd278: r = 272;
      10'd279: r = 256; 10'd280: r = 242; 10'd281: r = 228; 10'd282: r = 216; 10'd283: r = 204;
      10'd284: r = 192; 10'd285: r = 181; 10'd286: r = 171; 10'd287: r = 161; 10'd288: r = 152;
      10'd289: r = 144; 10'd290: r = 136; 10'd291: r = 128; 10'd292: r = 121; 10'd293: r = 114;
      10'd294: r = 108; 10'd295: r = 0;
      10'd296: r = 907; 10'd297: r = 856; 10'd298: r = 808; 10'd299: r = 762; 10'd300: r = 720;
      10'd301: r = 678; 10'd302: r = 640; 10'd303: r = 604; 10'd304: r = 570; 10'd305: r = 538;
      10'd306: r = 508; 10'd307: r = 480; 10'd308: r = 453; 10'd309: r = 428; 10'd310: r = 404;
      10'd311: r = 381; 10'd312: r = 360; 10'd313: r = 339; 10'd314: r = 320; 10'd315: r = 302;
      10'd316: r = 285; 10'd317: r = 269; 10'd318: r = 254; 10'd319: r = 240; 10'd320: r = 226;
      10'd321: r = 214; 10'd322: r = 202; 10'd323: r = 190; 10'd324: r = 180; 10'd325: r = 170;
      10'd326: r = 160; 10'd327: r = 151; 10'd328: r = 143; 10'd329: r = 135; 10'd330: r = 127;
      10'd331: r = 120; 10'd332: r = 0;
      10'd333: r = 900; 10'd334: r = 850; 10'd335: r = 802; 10'd336: r = 757; 10'd337: r = 715;
      10'd338: r = 675; 10'd339: r = 636; 10'd340: r = 601; 10'd341: r = 567; 10'd342: r = 535;
      10'd343: r = 505; 10'd344: r = 477; 10'd345: r = 450; 10'd346: r = 425; 10'd347: r = 401;
      10'd348: r = 379; 10'd349: r = 357; 10'd350: r = 337; 10'd351: r = 318; 10'd352: r = 300;
      10'd353: r = 284; 10'd354: r = 268; 10'd355: r = 253; 10'd356: r = 238; 10'd357: r = 225;
      10'd358: r = 212; 10'd359: r = 200; 10'd360: r = 189; 10'd361: r = 179; 10'd362: r = 169;
      10'd363: r = 159; 10'd364: r = 150; 10'd365: r = 142; 10'd366: r = 134; 10'd367: r = 126;
      10'd368: r = 119; 10'd369: r = 0;
      10'd370: r = 894; 10'd371: r = 844; 10'd372: r = 796; 10'd373: r = 752; 10'd374: r = 709;
      10'd375: r = 670; 10'd376: r = 632; 10'd377: r = 597; 10'd378: r = 563; 10'd379: r = 532;
      10'd380: r = 502; 10'd381: r = 474; 10'd382: r = 447; 10'd383: r = 422; 10'd384: r = 398;
      10'd385: r = 376; 10'd386: r = 355; 10'd387: r = 335; 10'd388: r = 316; 10'd389: r = 298;
      10'd390: r = 282; 10'd391: r = 266; 10'd392: r = 251; 10'd393: r = 237; 10'd394: r = 223;
      10'd395: r = 211; 10'd396: r = 199; 10'd397: r = 188; 10'd398: r = 177; 10'd399: r = 167;
      10'd400: r = 158; 10'd401: r = 149; 10'd402: r = 141; 10'd403: r = 133; 10'd404: r = 125;
      10'd405: r = 118; 10'd406: r = 0;
      10'd407: r = 887; 10'd408: r = 838; 10'd409: r = 791; 10'd410: r = 746; 10'd411: r = 704;
      10'd412: r = 665; 10'd413: r = 628; 10'd414: r = 592; 10'd415: r = 559; 10'd416: r = 528;
      10'd417: r = 498; 10'd418: r = 470; 10'd419: r = 444; 10'd420: r = 419; 10'd421: r = 395;
      10'd422: r = 373; 10'd423: r = 352; 10'd424: r = 332; 10'd425: r = 314; 10'd426: r = 296;
      10'd427: r = 280; 10'd428: r = 264; 10'd429: r = 249; 10'd430: r = 235; 10'd431: r = 222;
      10'd432: r = 209; 10'd433: r = 198; 10'd434: r = 187; 10'd435: r = 176; 10'd436: r = 166;
      10'd437: r = 157; 10'd438: r = 148; 10'd439: r = 140; 10'd440: r = 132; 10'd441: r = 125;
      10'd442: r = 118; 10'd443: r = 0;
      10'd444: r = 881; 10'd445: r = 832; 10'd446: r = 785; 10'd447: r = 741; 10'd448: r = 699;
      10'd449: r = 660; 10'd450: r = 623; 10'd451: r = 588; 10'd452: r = 555; 10'd453: r = 524;
      10'd454: r = 494; 10'd455: r = 467; 10'd456: r = 441; 10'd457: r = 416; 10'd458: r = 392;
      10'd459: r = 370; 10'd460: r = 350; 10'd461: r = 330; 10'd462: r = 312; 10'd463: r = 294;
      10'd464: r = 278; 10'd465: r = 262; 10'd466: r = 247; 10'd467: r = 233; 10'd468: r = 220;
      10'd469: r = 208; 10'd470: r = 196; 10'd471: r = 185; 10'd472: r = 175; 10'd473: r = 165;
      10'd474: r = 156; 10'd475: r = 147; 10'd476: r = 139; 10'd477: r = 131; 10'd478: r = 123;
      10'd479: r = 117; 10'd480: r = 0;
      10'd481: r = 875; 10'd482: r = 826; 10'd483: r = 779; 10'd484: r = 736; 10'd485: r = 694;
      10'd486: r = 655; 10'd487: r = 619; 10'd488: r = 584; 10'd489: r = 551; 10'd490: r = 520;
      10'd491: r = 491; 10'd492: r = 463; 10'd493: r = 437; 10'd494: r = 413; 10'd495: r = 390;
      10'd496: r = 368; 10'd497: r = 347; 10'd498: r = 328; 10'd499: r = 309; 10'd500: r = 292;
      10'd501: r = 276; 10'd502: r = 260; 10'd503: r = 245; 10'd504: r = 232; 10'd505: r = 219;
      10'd506: r = 206; 10'd507: r = 195; 10'd508: r = 184; 10'd509: r = 174; 10'd510: r = 164;
      10'd511: r = 155; 10'd512: r = 146; 10'd513: r = 138; 10'd514: r = 130; 10'd515: r = 123;
      10'd516: r = 116; 10'd517: r = 0;
      10'd518: r = 868; 10'd519: r = 820; 10'd520: r = 774; 10'd521: r = 730; 10'd522: r = 689;
      10'd523: r = 651; 10'd524: r = 614; 10'd525: r = 580; 10'd526: r = 547; 10'd527: r = 516;
      10'd528: r = 487; 10'd529: r = 460; 10'd530: r = 434; 10'd531: r = 410; 10'd532: r = 387;
      10'd533: r = 365; 10'd534: r = 345; 10'd535: r = 325; 10'd536: r = 307; 10'd537: r = 290;
      10'd538: r = 274; 10'd539: r = 258; 10'd540: r = 244; 10'd541: r = 230; 10'd542: r = 217;
      10'd543: r = 205; 10'd544: r = 193; 10'd545: r = 183; 10'd546: r = 172; 10'd547: r = 163;
      10'd548: r = 154; 10'd549: r = 145; 10'd550: r = 137; 10'd551: r = 129; 10'd552: r = 122;
      10'd553: r = 115; 10'd554: r = 0;
      10'd555: r = 862; 10'd556: r = 814; 10'd557: r = 768; 10'd558: r = 725; 10'd559: r = 684;
      10'd560: r = 646; 10'd561: r = 610; 10'd562: r = 575; 10'd563: r = 543; 10'd564: r = 513;
      10'd565: r = 484; 10'd566: r = 457; 10'd567: r = 431; 10'd568: r = 407; 10'd569: r = 384;
      10'd570: r = 363; 10'd571: r = 342; 10'd572: r = 323; 10'd573: r = 305; 10'd574: r = 288;
      10'd575: r = 272; 10'd576: r = 256; 10'd577: r = 242; 10'd578: r = 228; 10'd579: r = 216;
      10'd580: r = 203; 10'd581: r = 192; 10'd582: r = 181; 10'd583: r = 171; 10'd584: r = 161;
      10'd585: r = 152; 10'd586: r = 144; 10'd587: r = 136; 10'd588: r = 128; 10'd589: r = 121;
      10'd590: r = 114; 10'd591: r = 0;
      10'd592: r = 774; 10'd593: r = 1800; 10'd594: r = 2314; 10'd595: r = 3087;
      10'd596: r = 4113; 10'd597: r = 4627; 10'd598: r = 5400; 10'd599: r = 6426;
      10'd600: r = 6940; 10'd601: r = 7713; 10'd602: r = 8739; 10'd603: r = 9253;
      10'd604: r = 24625; 10'd605: r = 12851; 10'd606: r = 13365;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sine_tab(input logic [4:0] idx);
    logic [7:0] r;
    unique case (idx)
      5'd0: r = 8'h00; 5'd1: r = 8'h18; 5'd2: r = 8'h31; 5'd3: r = 8'h4A;
      5'd4: r = 8'h61; 5'd5: r = 8'h78; 5'd6: r = 8'h8D; 5'd7: r = 8'hA1;
      5'd8: r = 8'hB4; 5'd9: r = 8'hC5; 5'd10: r = 8'hD4; 5'd11: r = 8'hE0;
      5'd12: r = 8'hEB; 5'd13: r = 8'hF4; 5'd14: r = 8'hFA; 5'd15: r = 8'hFD;
      5'd16: r = 8'hFF; 5'd17: r = 8'hFD; 5'd18: r = 8'hFA; 5'd19: r = 8'hF4;
      5'd20: r = 8'hEB; 5'd21: r = 8'hE0; 5'd22: r = 8'hD4; 5'd23: r = 8'hC5;
      5'd24: r = 8'hB4; 5'd25: r = 8'hA1; 5'd26: r = 8'h8D; 5'd27: r = 8'h78;
      5'd28: r = 8'h61; 5'd29: r = 8'h4A; 5'd30: r = 8'h31; 5'd31: r = 8'h18;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/tcfx_queue.sv
// Small word queue between the front and back parts, and at the result side.
// Depends on nothing but its parameters.
`default_nettype none
module tcfx_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire logic [Width-1:0] wdata,
  output logic full,
  input wire logic pop,
  output logic [Width-1:0] rdata,
  output logic empty
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  logic [Width-1:0] mem [Depth];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0] count;
  logic do_push, do_pop;

  assign full = (count == (AW+1)'(Depth));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (do_pop) rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
    if (do_push) mem[wptr] <= wdata;
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !empty)
    else $error("queue full and empty together");
  assert property (@(posedge clk) disable iff (rst) (empty && !push) |=> empty)
    else $error("queue filled without a push");
  assert property (@(posedge clk) disable iff (rst)
      (full && !pop) |=> full)
    else $error("queue drained without a pop");
endmodule
`default_nettype wire

>>> src/tcfx_back.sv
// Effect execution: channel state and a sequencer for the period table scans.
// Depends on tcfx_pkg.
`default_nettype none
module tcfx_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire tcfx_pkg::item_t in_item,
  output logic in_take,
  output logic out_valid,
  output logic [11:0] out_period,
  output logic out_pvalid,
  output logic [6:0] out_volume,
  output logic out_restart,
  input wire logic out_ready
);
  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_LOAD_SCAN, S_LOAD_READ, S_TGT_SCAN, S_TGT_READ,
    S_TICK, S_GLISS, S_ARP_SCAN, S_ARP_READ, S_RETRIG, S_DONE
  } state_t;

  state_t state;
  logic [15:0] cur_period, target_period;
  logic [6:0] cur_volume;
  logic [3:0] cur_finetune, gliss_on;
  logic [11:0] row_note, row_command;
  logic slide_down_dir;
  logic [7:0] slide_speed, vib_settings, vib_phase, trem_settings, trem_phase;
  logic [7:0] wave_modes, step_mask;
  logic [4:0] tick_now;
  logic [4:0] rem;
  logic [5:0] idx;
  logic [11:0] o_per;
  logic o_valid, o_restart;
  logic [6:0] o_vol;
  logic after_load;

  logic [9:0] base;
  logic signed [16:0] sp;
  logic signed [15:0] tab_scan, tab_arp;
  logic [3:0] rc_cmd, rc_ext, rc_x;
  logic [7:0] rc_p;

  // Remainder of a tick index by three, by compare and subtract.
  function automatic logic [1:0] mod3(input logic [4:0] t);
    logic [4:0] r;
    r = t;
    if (r >= 5'd24) r = r - 5'd24;
    if (r >= 5'd12) r = r - 5'd12;
    if (r >= 5'd6) r = r - 5'd6;
    if (r >= 5'd3) r = r - 5'd3;
    return r[1:0];
  endfunction

  assign base = 10'(cur_finetune) * 10'(tcfx_pkg::RowLen);
  assign sp = 17'(signed'(cur_period));
  assign rc_cmd = row_command[11:8];
  assign rc_ext = row_command[7:4];
  assign rc_x = row_command[3:0];
  assign rc_p = row_command[7:0];

  // Scan entry: row 0 for the load, the finetuned row otherwise.
  always_comb begin
    logic [9:0] a;
    a = (state == S_LOAD_SCAN) ? 10'(idx) : base + 10'(idx);
    tab_scan = tcfx_pkg::per_tab(a);
  end
  always_comb begin
    logic [3:0] arp;
    arp = (mod3(tick_now) == 2'd1) ? rc_ext : rc_x;
    tab_arp = tcfx_pkg::per_tab(base + 10'(idx) + 10'(arp));
  end

  assign in_take = (state == S_IDLE) && in_valid;
  assign out_valid = (state == S_DONE);
  assign out_period = o_per;
  assign out_pvalid = o_valid;
  assign out_volume = o_vol;
  assign out_restart = o_restart;

  function automatic logic [7:0] wave_value(input logic [1:0] kind, input logic [7:0] ph,
                                            input logic [7:0] rph);
    logic [4:0] i;
    logic [7:0] r;
    i = ph[6:2];
    if (kind == 2'd0) r = tcfx_pkg::sine_tab(i);
    else if (kind == 2'd1) r = rph[7] ? 8'd255 - {i, 3'b0} : {i, 3'b0};
    else r = 8'd255;
    return r;
  endfunction

  function automatic logic [7:0] merge(input logic [7:0] s, input logic [7:0] p);
    logic [7:0] r;
    r = s;
    if (p[3:0] != 4'd0) r = {r[7:4], p[3:0]};
    if (p[7:4] != 4'd0) r = {p[7:4], r[3:0]};
    return r;
  endfunction

  function automatic logic [6:0] vol_dn(input logic [6:0] v, input logic [7:0] d);
    return ({1'b0, v} > d) ? 7'(8'(v) - d) : 7'd0;
  endfunction

  function automatic logic [6:0] vol_up(input logic [6:0] v, input logic [7:0] d);
    logic [8:0] s;
    s = 9'(v) + 9'(d);
    return (s > 9'(tcfx_pkg::VolMax)) ? tcfx_pkg::VolMax : 7'(s);
  endfunction

  always_ff @(posedge clk) begin
    logic [15:0] np, amt;
    logic signed [17:0] p;
    logic [7:0] d8, ts;
    logic [11:0] dv;
    logic [6:0] v;
    logic [5:0] ii;
    logic [3:0] x;
    if (rst) begin
      state <= S_IDLE;
      cur_period <= '0; target_period <= '0; cur_volume <= '0; cur_finetune <= '0;
      row_note <= '0; row_command <= '0; slide_down_dir <= 1'b0; slide_speed <= '0;
      vib_settings <= '0; vib_phase <= '0; trem_settings <= '0; trem_phase <= '0;
      wave_modes <= '0; gliss_on <= '0; step_mask <= '0;
      idx <= '0; tick_now <= '0; rem <= '0; after_load <= 1'b0;
      o_per <= '0; o_valid <= 1'b0; o_restart <= 1'b0; o_vol <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            o_per <= '0; o_valid <= 1'b0; o_restart <= 1'b0;
            state <= in_item.mode ? S_TICK : S_ROW;
            if (!in_item.mode) begin
              tick_now <= '0;
              row_note <= in_item.note_period;
              row_command <= {in_item.command, in_item.param};
              if (in_item.sample_given) begin
                cur_finetune <= in_item.sample_finetune;
                cur_volume <= (in_item.sample_volume > tcfx_pkg::VolMax) ?
                              tcfx_pkg::VolMax : in_item.sample_volume;
              end
            end else begin
              tick_now <= in_item.tick_index;
            end
          end
        end
        S_ROW: begin
          // Dispatch of a row word; row effects follow the scans.
          idx <= '0;
          after_load <= 1'b0;
          if (row_note == 12'd0) begin
            after_load <= 1'b1;
            state <= S_LOAD_READ;
          end else if (row_command[11:4] == {tcfx_pkg::CmdExt, tcfx_pkg::ExtFinetune}) begin
            cur_finetune <= rc_x;
            state <= S_LOAD_SCAN;
          end else if (rc_cmd == tcfx_pkg::CmdTone || rc_cmd == tcfx_pkg::CmdToneVol) begin
            state <= S_TGT_SCAN;
          end else begin
            state <= S_LOAD_SCAN;
          end
        end
        S_LOAD_SCAN: begin
          if (idx < 6'd36 && signed'({4'b0, row_note}) < tab_scan) idx <= idx + 6'd1;
          else state <= S_LOAD_READ;
        end
        S_TGT_SCAN: begin
          if (idx < 6'd36 && signed'({4'b0, row_note}) < tab_scan) idx <= idx + 6'd1;
          else begin
            if (cur_finetune[3] && idx != 6'd0) idx <= idx - 6'd1;
            state <= S_TGT_READ;
          end
        end
        S_TGT_READ: begin
          np = 16'(tab_scan);
          slide_down_dir <= 1'b0;
          target_period <= np;
          if (sp == signed'({1'b0, np})) target_period <= '0;
          else if (sp > signed'({1'b0, np})) slide_down_dir <= 1'b1;
          after_load <= 1'b1;
          state <= S_LOAD_READ;
        end
        S_LOAD_READ: begin
          // Finish a table load (after_load low), then run row effects.
          np = cur_period;
          v = cur_volume;
          x = rc_x;
          ts = step_mask;
          if (!after_load) begin
            np = 16'(tcfx_pkg::per_tab(base + 10'(idx)));
            if (row_command[11:4] != {tcfx_pkg::CmdExt, tcfx_pkg::ExtDelay}) begin
              o_restart <= 1'b1;
              if (!wave_modes[2]) vib_phase <= '0;
              if (!wave_modes[6]) trem_phase <= '0;
              o_per <= np[11:0]; o_valid <= 1'b1;
            end
          end
          unique case (rc_cmd)
            tcfx_pkg::CmdRetrig, 4'hB, 4'hD, 4'hF: ;
            tcfx_pkg::CmdSetVol: v = (rc_p > 8'd64) ? tcfx_pkg::VolMax : 7'(rc_p);
            tcfx_pkg::CmdExt: begin
              priority case (rc_ext)
                tcfx_pkg::ExtFineUp, tcfx_pkg::ExtFineDown: begin
                  amt = 16'(rc_p & 8'h0F);
                  ts = 8'hFF;
                  if (rc_ext == tcfx_pkg::ExtFineUp) begin
                    np = np - amt;
                    if (np[11:0] < tcfx_pkg::PerMin) np = {np[15:12], tcfx_pkg::PerMin};
                  end else begin
                    np = np + amt;
                    if (np[11:0] > tcfx_pkg::PerMax) np = {np[15:12], tcfx_pkg::PerMax};
                  end
                  o_per <= np[11:0]; o_valid <= 1'b1;
                end
                tcfx_pkg::ExtGliss: gliss_on <= x;
                tcfx_pkg::ExtVibWave: wave_modes <= {wave_modes[7:4], x};
                tcfx_pkg::ExtFinetune: cur_finetune <= x;
                tcfx_pkg::ExtTremWave: wave_modes <= {x, wave_modes[3:0]};
                // On a row without a note, tick zero retriggers when x is nonzero.
                tcfx_pkg::ExtRetrig: if (x != 4'd0 && row_note == 12'd0) begin
                  o_per <= np[11:0]; o_valid <= 1'b1; o_restart <= 1'b1;
                end
                tcfx_pkg::ExtFineVolUp: v = vol_up(v, 8'(x));
                tcfx_pkg::ExtFineVolDown: v = vol_dn(v, 8'(x));
                tcfx_pkg::ExtCut: if (x == 4'd0) v = '0;
                tcfx_pkg::ExtDelay: if (x == 4'd0 && row_note != 12'd0) begin
                  o_per <= np[11:0]; o_valid <= 1'b1; o_restart <= 1'b1;
                end
                default: ;
              endcase
            end
            default: begin
              o_per <= np[11:0]; o_valid <= 1'b1;
            end
          endcase
          cur_period <= np;
          cur_volume <= v;
          step_mask <= ts;
          o_vol <= v;
          state <= S_DONE;
        end
        S_TICK: begin
          np = cur_period;
          v = cur_volume;
          o_vol <= cur_volume;
          x = rc_x;
          state <= S_DONE;
          if (row_command != 12'd0) begin
            unique case (rc_cmd)
              tcfx_pkg::CmdArp: begin
                if (mod3(tick_now) == 2'd0) begin
                  o_per <= np[11:0]; o_valid <= 1'b1;
                end else begin
                  idx <= '0;
                  state <= S_ARP_SCAN;
                end
              end
              tcfx_pkg::CmdPortaUp, tcfx_pkg::CmdPortaDown: begin
                amt = 16'(rc_p & step_mask);
                step_mask <= 8'hFF;
                if (rc_cmd == tcfx_pkg::CmdPortaUp) begin
                  np = np - amt;
                  if (np[11:0] < tcfx_pkg::PerMin) np = {np[15:12], tcfx_pkg::PerMin};
                end else begin
                  np = np + amt;
                  if (np[11:0] > tcfx_pkg::PerMax) np = {np[15:12], tcfx_pkg::PerMax};
                end
                o_per <= np[11:0]; o_valid <= 1'b1;
              end
              tcfx_pkg::CmdTone, tcfx_pkg::CmdToneVol: begin
                d8 = slide_speed;
                if (rc_cmd == tcfx_pkg::CmdTone && rc_p != 8'd0) begin
                  d8 = rc_p;
                  slide_speed <= rc_p;
                  row_command <= {rc_cmd, 8'd0};
                end
                if (rc_cmd == tcfx_pkg::CmdToneVol)
                  v = (rc_p[7:4] == 4'd0) ? vol_dn(v, 8'(rc_p[3:0])) : vol_up(v, 8'(rc_p[7:4]));
                if (target_period != 16'd0) begin
                  p = 18'(sp);
                  if (slide_down_dir) begin
                    p = p - 18'(d8);
                    if (p <= signed'({2'b0, target_period})) begin
                      p = signed'({2'b0, target_period}); target_period <= '0;
                    end
                  end else begin
                    p = p + 18'(d8);
                    if (p >= signed'({2'b0, target_period})) begin
                      p = signed'({2'b0, target_period}); target_period <= '0;
                    end
                  end
                  np = 16'(p);
                  if (gliss_on == 4'd0) begin
                    o_per <= np[11:0]; o_valid <= 1'b1;
                  end else begin
                    idx <= '0;
                    state <= S_GLISS;
                  end
                end
              end
              tcfx_pkg::CmdVibrato, tcfx_pkg::CmdVibVol: begin
                ts = (rc_cmd == tcfx_pkg::CmdVibrato) ? merge(vib_settings, rc_p) : vib_settings;
                vib_settings <= ts;
                d8 = wave_value(wave_modes[1:0], vib_phase, vib_phase);
                dv = 12'(d8) * 12'(ts[3:0]);
                amt = 16'(dv[11:7]);
                o_per <= vib_phase[7] ? 12'(np - amt) : 12'(np + amt);
                o_valid <= 1'b1;
                vib_phase <= vib_phase + {2'b0, ts[7:4], 2'b0};
                if (rc_cmd == tcfx_pkg::CmdVibVol)
                  v = (rc_p[7:4] == 4'd0) ? vol_dn(v, 8'(rc_p[3:0])) : vol_up(v, 8'(rc_p[7:4]));
              end
              tcfx_pkg::CmdTremolo: begin
                o_per <= np[11:0]; o_valid <= 1'b1;
                ts = merge(trem_settings, rc_p);
                trem_settings <= ts;
                d8 = wave_value(wave_modes[5:4], trem_phase, vib_phase);
                dv = 12'(d8) * 12'(ts[3:0]);
                o_vol <= trem_phase[7] ? vol_dn(v, 8'(dv[11:6])) : vol_up(v, 8'(dv[11:6]));
                trem_phase <= trem_phase + {2'b0, ts[7:4], 2'b0};
              end
              tcfx_pkg::CmdVolSlide: begin
                o_per <= np[11:0]; o_valid <= 1'b1;
                v = (rc_p[7:4] == 4'd0) ? vol_dn(v, 8'(rc_p[3:0])) : vol_up(v, 8'(rc_p[7:4]));
              end
              tcfx_pkg::CmdExt: begin
                priority case (rc_ext)
                  tcfx_pkg::ExtFineUp, tcfx_pkg::ExtFineDown: if (tick_now == 5'd0) begin
                    amt = 16'(rc_p & 8'h0F);
                    step_mask <= 8'hFF;
                    if (rc_ext == tcfx_pkg::ExtFineUp) begin
                      np = np - amt;
                      if (np[11:0] < tcfx_pkg::PerMin) np = {np[15:12], tcfx_pkg::PerMin};
                    end else begin
                      np = np + amt;
                      if (np[11:0] > tcfx_pkg::PerMax) np = {np[15:12], tcfx_pkg::PerMax};
                    end
                    o_per <= np[11:0]; o_valid <= 1'b1;
                  end
                  tcfx_pkg::ExtGliss: gliss_on <= x;
                  tcfx_pkg::ExtVibWave: wave_modes <= {wave_modes[7:4], x};
                  tcfx_pkg::ExtFinetune: cur_finetune <= x;
                  tcfx_pkg::ExtTremWave: wave_modes <= {x, wave_modes[3:0]};
                  tcfx_pkg::ExtRetrig: begin
                    // Retrigger every x ticks, except at tick zero of a note row.
                    if (x != 4'd0 && !(tick_now == 5'd0 && row_note != 12'd0)) begin
                      rem <= tick_now;
                      state <= S_RETRIG;
                    end
                  end
                  tcfx_pkg::ExtFineVolUp: if (tick_now == 5'd0) v = vol_up(v, 8'(x));
                  tcfx_pkg::ExtFineVolDown: if (tick_now == 5'd0) v = vol_dn(v, 8'(x));
                  tcfx_pkg::ExtCut: if (tick_now == 5'(x)) v = '0;
                  tcfx_pkg::ExtDelay: if (tick_now == 5'(x) && row_note != 12'd0) begin
                    o_per <= np[11:0]; o_valid <= 1'b1; o_restart <= 1'b1;
                  end
                  default: ;
                endcase
              end
              default: begin
                o_per <= np[11:0]; o_valid <= 1'b1;
              end
            endcase
            if (rc_cmd != tcfx_pkg::CmdTremolo) o_vol <= v;
          end
          cur_period <= np;
          cur_volume <= v;
        end
        S_GLISS: begin
          // Snap the slid period to the first table entry at or below it.
          if (idx < 6'd37 && sp < 17'(tab_scan)) idx <= idx + 6'd1;
          else begin
            ii = (idx >= 6'd37) ? 6'd35 : idx;
            o_per <= 12'(tcfx_pkg::per_tab(base + 10'(ii)));
            o_valid <= 1'b1;
            state <= S_DONE;
          end
        end
        S_ARP_SCAN: begin
          if (idx >= 6'd37) state <= S_DONE;
          else if (sp >= 17'(tab_scan)) state <= S_ARP_READ;
          else idx <= idx + 6'd1;
        end
        S_ARP_READ: begin
          o_per <= 12'(tab_arp);
          o_valid <= 1'b1;
          state <= S_DONE;
        end
        S_RETRIG: begin
          // The tick is a multiple of the interval when repeated subtraction ends at zero.
          if (rem >= 5'(rc_x)) rem <= rem - 5'(rc_x);
          else begin
            if (rem == 5'd0) begin
              o_per <= cur_period[11:0]; o_valid <= 1'b1; o_restart <= 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_take |=> !out_valid)
    else $error("result shown in the cycle after a word was taken");
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> cur_volume <= 7'd64)
    else $error("volume out of range");
  assert property (@(posedge clk) disable iff (rst) (out_restart && out_valid) |-> out_pvalid)
    else $error("restart without a period");
endmodule
`default_nettype wire

>>> src/tracker_channel_effect_engine.sv
// Top level of the tracker channel effect engine.
// Uses tcfx_pkg, tcfx_queue and tcfx_back.
//
// Usage: push a row word (mode 0) at each new row and a tick word (mode 1)
// at each effect tick while full is low. Every word gives exactly one result
// word: period_out, period_valid, volume_out, restart; it waits on the
// result ports while empty is low and leaves on pop.
// A two-entry queue takes words ahead of the effect sequencer, and a
// two-entry queue holds finished results, so a stalled receiver only stops
// the sequencer once the result queue is full.
// A row with a note scans a 37-entry row of the period table one entry a
// cycle; arpeggio and glissando ticks scan one finetuned row likewise, and a
// retrigger tick counts out its interval by repeated subtraction.
// Words are handled one at a time: no new word is taken before the last
// result has been handed to the result queue.
// Reset clears all channel state to zero and empties both queues.
`default_nettype none
module tracker_channel_effect_engine #(
  parameter int QueueDepth = tcfx_pkg::QueueDepth
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  output logic full,
  input wire logic mode,
  input wire logic [11:0] note_period,
  input wire logic sample_given,
  input wire logic [3:0] sample_finetune,
  input wire logic [6:0] sample_volume,
  input wire logic [3:0] command,
  input wire logic [7:0] param,
  input wire logic [4:0] tick_index,
  output logic empty,
  input wire logic pop,
  output logic [11:0] period_out,
  output logic period_valid,
  output logic [6:0] volume_out,
  output logic restart
);
  localparam int IW = $bits(tcfx_pkg::item_t);
  tcfx_pkg::item_t wr_item, q_item;
  logic q_empty, q_full_unused, take;
  logic b_valid, r_full;
  logic [11:0] b_per;
  logic b_pv, b_rs;
  logic [6:0] b_vol;

  assign wr_item = '{mode: mode, note_period: note_period, sample_given: sample_given,
                     sample_finetune: sample_finetune, sample_volume: sample_volume,
                     command: command, param: param, tick_index: tick_index};

  tcfx_queue #(.Width(IW), .Depth(QueueDepth)) u_inq (
    .clk(clk), .rst(rst), .push(push), .wdata(wr_item), .full(full),
    .pop(take), .rdata(q_item), .empty(q_empty)
  );

  tcfx_back u_back (
    .clk(clk), .rst(rst), .in_valid(!q_empty), .in_item(q_item), .in_take(take),
    .out_valid(b_valid), .out_period(b_per), .out_pvalid(b_pv), .out_volume(b_vol),
    .out_restart(b_rs), .out_ready(!r_full)
  );

  assign q_full_unused = 1'b0;

  tcfx_queue #(.Width(21), .Depth(QueueDepth)) u_outq (
    .clk(clk), .rst(rst), .push(b_valid || q_full_unused), .wdata({b_per, b_pv, b_vol, b_rs}),
    .full(r_full), .pop(pop), .rdata({period_out, period_valid, volume_out, restart}),
    .empty(empty)
  );
endmodule
`default_nettype wire
